// ===== design/ted_pkg.sv =====
`default_nettype none

package ted_pkg;

   // Longest text whose output positions are counted exactly; positions saturate here.
   localparam int unsigned MaxTextLength = 65535;
   localparam logic [15:0] PosCap =
      (MaxTextLength < 65535) ? 16'(MaxTextLength) : 16'hFFFF;

   // Depth of the result queue behind the decoder. It must hold at least two entries.
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      ModeNormal  = 3'd0,
      ModeEscape  = 3'd1,
      ModeNumber  = 3'd2,
      ModeSlice   = 3'd3,
      ModeSwallow = 3'd4
   } mode_type;

   // Kinds of numeric escape.
   localparam logic [1:0] KindOctal   = 2'd0;
   localparam logic [1:0] KindHex     = 2'd1;
   localparam logic [1:0] KindUnicode = 2'd2;

   // Error codes carried on the final result of a string.
   localparam logic [2:0] ErrNone      = 3'd0;
   localparam logic [2:0] ErrUnclosed  = 3'd1;
   localparam logic [2:0] ErrTrailing  = 3'd2;
   localparam logic [2:0] ErrUnknown   = 3'd3;
   localparam logic [2:0] ErrBadNumber = 3'd4;
   localparam logic [2:0] ErrRange     = 3'd5;

   // Character codes.
   localparam logic [15:0] ChTab       = 16'h0009;
   localparam logic [15:0] ChNewline   = 16'h000A;
   localparam logic [15:0] ChReturn    = 16'h000D;
   localparam logic [15:0] ChQuote     = 16'h0022;
   localparam logic [15:0] ChApos      = 16'h0027;
   localparam logic [15:0] Ch0         = 16'h0030;
   localparam logic [15:0] Ch7         = 16'h0037;
   localparam logic [15:0] Ch8         = 16'h0038;
   localparam logic [15:0] Ch9         = 16'h0039;
   localparam logic [15:0] ChUpA       = 16'h0041;
   localparam logic [15:0] ChUpF       = 16'h0046;
   localparam logic [15:0] ChUpU       = 16'h0055;
   localparam logic [15:0] ChUpX       = 16'h0058;
   localparam logic [15:0] ChBackslash = 16'h005C;
   localparam logic [15:0] ChLowA      = 16'h0061;
   localparam logic [15:0] ChLowF      = 16'h0066;
   localparam logic [15:0] ChLowN      = 16'h006E;
   localparam logic [15:0] ChLowR      = 16'h0072;
   localparam logic [15:0] ChLowT      = 16'h0074;
   localparam logic [15:0] ChLowU      = 16'h0075;
   localparam logic [15:0] ChLowX      = 16'h0078;
   localparam logic [15:0] ChLBrace    = 16'h007B;
   localparam logic [15:0] ChRBrace    = 16'h007D;
   localparam logic [15:0] ByteMax     = 16'h00FF;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  kind;
      logic [2:0]  digits;
      logic [15:0] acc;
      logic [15:0] pos;
      logic [15:0] slice_start;
      logic [15:0] slice_length;
      logic [2:0]  saved_error;
   } state_type;

   typedef struct packed {
      logic [15:0] out_char;
      logic        slice_closed;
      logic [15:0] slice_start;
      logic [15:0] slice_length;
      logic [2:0]  error;
      logic        out_last;
   } res_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v < PosCap) ? v + 16'd1 : PosCap;
   endfunction

   function automatic logic [2:0] kind_digits(input logic [1:0] kind);
      case (kind)
         KindOctal: kind_digits = 3'd3;
         KindHex:   kind_digits = 3'd2;
         default:   kind_digits = 3'd4;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== design/ted_decode.sv =====
`default_nettype none

module ted_decode (
   input  wire ted_pkg::state_type       cur,
   input  wire logic [15:0]              in_char,
   input  wire logic                     in_last,
   input  wire logic                     interp_en,
   output ted_pkg::state_type            nxt,
   output ted_pkg::res_type [1:0]        res,
   output logic [1:0]                    res_count
);
   import ted_pkg::*;

   logic        dig_ok;
   logic [3:0]  dig_val;
   logic [15:0] acc_shift;
   logic [15:0] acc_new;
   logic [2:0]  cnt_new;
   logic [15:0] esc_ch;
   logic        esc_hit;
   logic        a_emit;
   logic [15:0] a_ch;
   logic        a_closed;
   logic        a_last;
   logic        do_plain;
   logic        p_emit;
   logic        raise;
   logic [2:0]  raise_code;
   logic        raise_final;
   logic [1:0]  n;

   // Digit value of the current character for the kind of number in progress.
   always_comb begin
      dig_ok  = 1'b0;
      dig_val = 4'd0;
      if (in_char inside {[Ch0:Ch7]}) begin
         dig_ok  = 1'b1;
         dig_val = in_char[3:0];
      end else if (cur.kind != KindOctal) begin
         if (in_char inside {[Ch8:Ch9]}) begin
            dig_ok  = 1'b1;
            dig_val = in_char[3:0];
         end else if (in_char inside {[ChLowA:ChLowF], [ChUpA:ChUpF]}) begin
            dig_ok  = 1'b1;
            dig_val = in_char[3:0] + 4'd9;
         end
      end
   end

   assign acc_shift = (cur.kind == KindOctal) ? {cur.acc[12:0], 3'b000}
                                              : {cur.acc[11:0], 4'b0000};
   assign acc_new   = acc_shift | {12'd0, dig_val};
   assign cnt_new   = cur.digits + 3'd1;

   always_comb begin
      nxt         = cur;
      res         = '0;
      n           = 2'd0;
      esc_ch      = '0;
      esc_hit     = 1'b0;
      a_emit      = 1'b0;
      a_ch        = '0;
      a_closed    = 1'b0;
      a_last      = 1'b0;
      do_plain    = 1'b0;
      p_emit      = 1'b0;
      raise       = 1'b0;
      raise_code  = ErrNone;
      raise_final = in_last;

      case (cur.mode)
         ModeEscape: begin
            case (in_char)
               ChLowT: begin
                  esc_ch  = ChTab;
                  esc_hit = 1'b1;
               end
               ChLowN: begin
                  esc_ch  = ChNewline;
                  esc_hit = 1'b1;
               end
               ChLowR: begin
                  esc_ch  = ChReturn;
                  esc_hit = 1'b1;
               end
               ChQuote, ChApos, ChLBrace, ChBackslash: begin
                  esc_ch  = in_char;
                  esc_hit = 1'b1;
               end
               ChLowX, ChUpX: begin
                  nxt.mode   = ModeNumber;
                  nxt.kind   = KindHex;
                  nxt.acc    = '0;
                  nxt.digits = '0;
                  raise      = in_last;
                  raise_code = ErrBadNumber;
               end
               ChLowU, ChUpU: begin
                  nxt.mode   = ModeNumber;
                  nxt.kind   = KindUnicode;
                  nxt.acc    = '0;
                  nxt.digits = '0;
                  raise      = in_last;
                  raise_code = ErrBadNumber;
               end
               default: begin
                  if (in_char inside {[Ch0:Ch7]}) begin
                     nxt.mode   = ModeNumber;
                     nxt.kind   = KindOctal;
                     nxt.acc    = {13'd0, in_char[2:0]};
                     nxt.digits = 3'd1;
                     raise      = in_last;
                     raise_code = ErrBadNumber;
                  end else begin
                     raise      = 1'b1;
                     raise_code = ErrUnknown;
                  end
               end
            endcase
            if (esc_hit) begin
               nxt.mode = ModeNormal;
               a_emit   = 1'b1;
               a_ch     = esc_ch;
               a_last   = in_last;
            end
         end

         ModeNumber: begin
            if (dig_ok) begin
               nxt.acc    = acc_new;
               nxt.digits = cnt_new;
               if (cnt_new >= kind_digits(cur.kind)) begin
                  if (cur.kind != KindUnicode && acc_new > ByteMax) begin
                     raise      = 1'b1;
                     raise_code = ErrRange;
                  end else begin
                     nxt.mode = ModeNormal;
                     a_emit   = 1'b1;
                     a_ch     = acc_new;
                     a_last   = in_last;
                  end
               end else if (in_last) begin
                  raise      = 1'b1;
                  raise_code = ErrBadNumber;
               end
            end else if (cur.digits == 3'd0) begin
               raise      = 1'b1;
               raise_code = ErrBadNumber;
            end else if (cur.kind != KindUnicode && cur.acc > ByteMax) begin
               // The number closed by a non-digit is out of range: the string
               // is swallowed even when this character is its last.
               raise       = 1'b1;
               raise_code  = ErrRange;
               raise_final = 1'b0;
            end else begin
               nxt.mode = ModeNormal;
               a_emit   = 1'b1;
               a_ch     = cur.acc;
               do_plain = 1'b1;
            end
         end

         ModeSlice: begin
            nxt.slice_length = sat_inc(cur.slice_length);
            if (in_char == ChRBrace) begin
               nxt.mode = ModeNormal;
               a_emit   = 1'b1;
               a_ch     = in_char;
               a_closed = 1'b1;
               a_last   = in_last;
            end else if (in_last) begin
               raise      = 1'b1;
               raise_code = ErrUnclosed;
            end else begin
               a_emit = 1'b1;
               a_ch   = in_char;
            end
         end

         ModeSwallow: begin
            raise      = in_last;
            raise_code = cur.saved_error;
         end

         default: begin
            do_plain = 1'b1;
         end
      endcase

      // First character result of the step.
      if (a_emit) begin
         res[n[0]].out_char     = a_ch;
         res[n[0]].slice_closed = a_closed;
         res[n[0]].slice_start  = a_closed ? nxt.slice_start : 16'd0;
         res[n[0]].slice_length = a_closed ? nxt.slice_length : 16'd0;
         res[n[0]].error        = ErrNone;
         res[n[0]].out_last     = a_last;
         n       = n + 2'd1;
         nxt.pos = sat_inc(nxt.pos);
         if (a_last) begin
            nxt = '0;
         end
      end

      // Ordinary character handling, also for the character that ended a number.
      if (do_plain) begin
         nxt.mode = ModeNormal;
         if (in_char == ChLBrace && interp_en) begin
            if (in_last) begin
               raise      = 1'b1;
               raise_code = ErrUnclosed;
            end else begin
               nxt.slice_start  = nxt.pos;
               nxt.slice_length = 16'd1;
               nxt.mode         = ModeSlice;
               p_emit           = 1'b1;
            end
         end else if (in_char == ChBackslash) begin
            if (in_last) begin
               raise      = 1'b1;
               raise_code = ErrTrailing;
            end else begin
               nxt.mode = ModeEscape;
            end
         end else begin
            p_emit = 1'b1;
         end
      end

      if (p_emit) begin
         res[n[0]].out_char     = in_char;
         res[n[0]].slice_closed = 1'b0;
         res[n[0]].slice_start  = 16'd0;
         res[n[0]].slice_length = 16'd0;
         res[n[0]].error        = ErrNone;
         res[n[0]].out_last     = in_last;
         n       = n + 2'd1;
         nxt.pos = sat_inc(nxt.pos);
         if (in_last) begin
            nxt = '0;
         end
      end

      if (raise) begin
         if (raise_final) begin
            res[n[0]].out_char     = 16'd0;
            res[n[0]].slice_closed = 1'b0;
            res[n[0]].slice_start  = 16'd0;
            res[n[0]].slice_length = 16'd0;
            res[n[0]].error        = raise_code;
            res[n[0]].out_last     = 1'b1;
            n   = n + 2'd1;
            nxt = '0;
         end else begin
            nxt.saved_error = raise_code;
            nxt.mode        = ModeSwallow;
         end
      end

      res_count = n;
   end

endmodule

`default_nettype wire

// ===== design/ted_result_queue.sv =====
`default_nettype none

module ted_result_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [1:0]            push_count,
   input  wire ted_pkg::res_type [1:0] push_data,
   input  wire logic                  pop,
   output ted_pkg::res_type           head,
   output logic                       not_empty,
   output logic                       room_for_two
);
   import ted_pkg::*;

   res_type              mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;
   logic [QueuePtrW-1:0] wr_ptr_next;

   assign wr_ptr_next  = wr_ptr_ff + QueuePtrW'(1);
   assign head         = mem_ff[rd_ptr_ff];
   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= QueueCntW'(QueueDepth - 2));

   assign wr_ptr_in = wr_ptr_ff + QueuePtrW'(push_count);
   assign rd_ptr_in = rd_ptr_ff + QueuePtrW'(pop);
   assign count_in  = count_ff + QueueCntW'(push_count) - QueueCntW'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_data[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/text_escape_decoder.sv =====
`default_nettype none

// Channel   Ports                                   Beat moves
// --------  --------------------------------------  --------------------------------
// req       req_valid, req_stall, req_in_*          one source character of a string
// rsp       rsp_valid, rsp_stall, rsp_*             one decoded character or error
// csr       csr_valid, csr_ready, csr_*             interpolation enable bit
//
// The decoder takes one character beat per cycle while req_stall is low. Its parse state
// is updated in the same cycle and the results go straight into a small result queue.
// A character that ends a short numeric escape gives two results; the queue drains them
// one per cycle while rsp_stall is low, and req_stall rises while the queue has fewer
// than two free entries. Reset is synchronous and clears the parse state, the queue and
// the enable bit. The csr channel is always ready.

module text_escape_decoder (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_in_char,
   input  wire logic        req_in_last,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_out_char,
   output logic             rsp_slice_closed,
   output logic [15:0]      rsp_slice_start,
   output logic [15:0]      rsp_slice_length,
   output logic [2:0]       rsp_error,
   output logic             rsp_out_last,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_interpolation_enable
);
   import ted_pkg::*;

   // Configuration: interpolation is sampled at each opening brace.
   logic interp_en_ff, interp_en_in;

   // Parse state carried from one character to the next.
   state_type state_ff, state_in;

   res_type [1:0] dec_res;
   logic [1:0]    dec_count;
   logic [1:0]    push_count;
   logic          req_accept;
   logic          rsp_accept;
   logic          queue_room;
   res_type       head;

   assign csr_ready    = 1'b1;
   assign interp_en_in = (csr_valid && csr_ready) ? csr_interpolation_enable
                                                  : interp_en_ff;

   // Input beats are taken only while the queue can hold the worst case of two results.
   assign req_stall  = !queue_room;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign push_count = req_accept ? dec_count : 2'd0;

   ted_decode u_decode (
      .cur       (state_ff),
      .in_char   (req_in_char),
      .in_last   (req_in_last),
      .interp_en (interp_en_ff),
      .nxt       (state_in),
      .res       (dec_res),
      .res_count (dec_count)
   );

   ted_result_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_data    (dec_res),
      .pop          (rsp_accept),
      .head         (head),
      .not_empty    (rsp_valid),
      .room_for_two (queue_room)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_en_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         interp_en_ff <= interp_en_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   assign rsp_out_char     = head.out_char;
   assign rsp_slice_closed = head.slice_closed;
   assign rsp_slice_start  = head.slice_start;
   assign rsp_slice_length = head.slice_length;
   assign rsp_error        = head.error;
   assign rsp_out_last     = head.out_last;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
module tb;
   import ted_pkg::*;

   // After the last expected result has come, an escape or a swallowed character may
   // still be in flight without producing anything, so the idle checks wait this long.
   localparam int SettleCycles  = 6;
   localparam int TailCycles    = 40;
   localparam int WatchdogLimit = 1000;
   localparam int RandomChars   = 1750;
   localparam int ReportLimit   = 50;

   typedef enum logic [1:0] {
      OpChar   = 2'd0,
      OpConfig = 2'd1,
      OpDrain  = 2'd2
   } beat_op_type;

   typedef struct {
      beat_op_type op;
      logic [15:0] ch;
      logic        last;
      logic        cfg;
      int unsigned gap;
   } source_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [15:0] req_in_char = 16'h0000;
   logic        req_in_last = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_out_char;
   logic        rsp_slice_closed;
   logic [15:0] rsp_slice_start;
   logic [15:0] rsp_slice_length;
   logic [2:0]  rsp_error;
   logic        rsp_out_last;

   logic        csr_valid                = 1'b0;
   logic        csr_ready;
   logic        csr_interpolation_enable = 1'b0;

   text_escape_decoder uut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_in_char              (req_in_char),
      .req_in_last              (req_in_last),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_out_char             (rsp_out_char),
      .rsp_slice_closed         (rsp_slice_closed),
      .rsp_slice_start          (rsp_slice_start),
      .rsp_slice_length         (rsp_slice_length),
      .rsp_error                (rsp_error),
      .rsp_out_last             (rsp_out_last),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_interpolation_enable (csr_interpolation_enable)
   );

   always #5 clock = ~clock;

   // Stimulus waiting to be driven, and decoded results waiting to be seen.
   source_beat_type source_beats[$];
   res_type         pending_results[$];
   logic [15:0]     word_buf[$];

   int          fail_count  = 0;
   int unsigned gap_max     = 7;
   int unsigned chars_total = 0;

   // Shadow copy of the decoder state. It is updated once for every accepted
   // character beat, in the order the beats are accepted.
   logic        interp_on      = 1'b0;
   mode_type    dec_mode       = ModeNormal;
   logic [1:0]  dec_kind       = KindOctal;
   logic [2:0]  dec_digits     = 3'd0;
   logic [15:0] dec_acc        = 16'd0;
   logic [15:0] dec_pos        = 16'd0;
   logic [15:0] dec_open_start = 16'd0;
   logic [15:0] dec_open_len   = 16'd0;
   logic [2:0]  dec_saved_err  = ErrNone;

   // ------------------------------------------------------------------
   // Decoder prediction
   // ------------------------------------------------------------------

   function automatic logic [15:0] capped_inc(input logic [15:0] v);
      return (v < PosCap) ? v + 16'd1 : PosCap;
   endfunction

   // Every string starts from a clean parse state; only the enable bit survives.
   function automatic void clear_string();
      dec_mode       = ModeNormal;
      dec_kind       = KindOctal;
      dec_digits     = 3'd0;
      dec_acc        = 16'd0;
      dec_pos        = 16'd0;
      dec_open_start = 16'd0;
      dec_open_len   = 16'd0;
      dec_saved_err  = ErrNone;
   endfunction

   function automatic void expect_result(input logic [15:0] ch, input logic closed,
                                         input logic [15:0] start, input logic [15:0] len,
                                         input logic [2:0] err, input logic last);
      res_type r;
      r.out_char     = ch;
      r.slice_closed = closed;
      r.slice_start  = start;
      r.slice_length = len;
      r.error        = err;
      r.out_last     = last;
      pending_results.push_back(r);
   endfunction

   // One decoded character goes out; a closing brace carries the slice report.
   function automatic void emit_decoded(input logic [15:0] ch, input logic closed,
                                        input logic last);
      if (closed) begin
         expect_result(ch, 1'b1, dec_open_start, dec_open_len, ErrNone, last);
      end else begin
         expect_result(ch, 1'b0, 16'd0, 16'd0, ErrNone, last);
      end
      dec_pos = capped_inc(dec_pos);
      if (last) begin
         clear_string();
      end
   endfunction

   // On the final character the error result goes out at once. Otherwise the
   // code is held and the rest of the string is swallowed.
   function automatic void flag_error(input logic [2:0] err, input logic last);
      if (last) begin
         expect_result(16'd0, 1'b0, 16'd0, 16'd0, err, 1'b1);
         clear_string();
      end else begin
         dec_saved_err = err;
         dec_mode      = ModeSwallow;
      end
   endfunction

   function automatic int digit_value(input logic [15:0] c, input logic [1:0] kind);
      if (c >= Ch0 && c <= Ch7) return int'(c) - int'(Ch0);
      if (kind == KindOctal) return -1;
      if (c >= Ch8 && c <= Ch9) return int'(c) - int'(Ch0);
      if (c >= ChLowA && c <= ChLowF) return int'(c) - int'(ChLowA) + 10;
      if (c >= ChUpA && c <= ChUpF) return int'(c) - int'(ChUpA) + 10;
      return -1;
   endfunction

   // Octal and \x values above one byte are out of range; \u takes any value.
   function automatic logic close_number(input logic last);
      if (dec_kind != KindUnicode && dec_acc > ByteMax) begin
         flag_error(ErrRange, last);
         return 1'b0;
      end
      dec_mode = ModeNormal;
      emit_decoded(dec_acc, 1'b0, last);
      return 1'b1;
   endfunction

   function automatic void plain_char(input logic [15:0] c, input logic last);
      dec_mode = ModeNormal;
      if (c == ChLBrace && interp_on) begin
         if (last) begin
            flag_error(ErrUnclosed, 1'b1);
         end else begin
            dec_open_start = dec_pos;
            dec_open_len   = 16'd1;
            dec_mode       = ModeSlice;
            emit_decoded(c, 1'b0, 1'b0);
         end
      end else if (c == ChBackslash) begin
         if (last) begin
            flag_error(ErrTrailing, 1'b1);
         end else begin
            dec_mode = ModeEscape;
         end
      end else begin
         emit_decoded(c, 1'b0, last);
      end
   endfunction

   function automatic void begin_number(input logic [1:0] kind, input logic [15:0] first,
                                        input logic [2:0] count, input logic last);
      dec_kind   = kind;
      dec_acc    = first;
      dec_digits = count;
      dec_mode   = ModeNumber;
      if (last) begin
         flag_error(ErrBadNumber, 1'b1);
      end
   endfunction

   function automatic void escape_char(input logic [15:0] c, input logic last);
      logic [15:0] ch;
      logic        known;
      ch    = c;
      known = 1'b1;
      case (c)
         ChLowT:  ch = ChTab;
         ChLowN:  ch = ChNewline;
         ChLowR:  ch = ChReturn;
         ChQuote, ChApos, ChLBrace, ChBackslash: ch = c;
         default: known = 1'b0;
      endcase
      if (known) begin
         dec_mode = ModeNormal;
         emit_decoded(ch, 1'b0, last);
      end else if (c == ChLowX || c == ChUpX) begin
         begin_number(KindHex, 16'd0, 3'd0, last);
      end else if (c == ChLowU || c == ChUpU) begin
         begin_number(KindUnicode, 16'd0, 3'd0, last);
      end else if (c >= Ch0 && c <= Ch7) begin
         begin_number(KindOctal, c - Ch0, 3'd1, last);
      end else begin
         flag_error(ErrUnknown, last);
      end
   endfunction

   function automatic void number_char(input logic [15:0] c, input logic last);
      int          d;
      logic [15:0] base;
      logic [2:0]  limit;
      d     = digit_value(c, dec_kind);
      base  = (dec_kind == KindOctal) ? 16'd8 : 16'd16;
      limit = (dec_kind == KindOctal) ? 3'd3 : (dec_kind == KindHex) ? 3'd2 : 3'd4;
      if (d >= 0) begin
         dec_acc    = dec_acc * base + 16'(d);
         dec_digits = dec_digits + 3'd1;
         if (dec_digits >= limit) begin
            void'(close_number(last));
         end else if (last) begin
            flag_error(ErrBadNumber, 1'b1);
         end
      end else if (dec_digits == 3'd0) begin
         flag_error(ErrBadNumber, last);
      end else if (close_number(1'b0)) begin
         // The non-digit that ended the number is decoded as a character of its own.
         plain_char(c, last);
      end
   endfunction

   function automatic void slice_char(input logic [15:0] c, input logic last);
      dec_open_len = capped_inc(dec_open_len);
      if (c == ChRBrace) begin
         dec_mode = ModeNormal;
         emit_decoded(c, 1'b1, last);
      end else if (last) begin
         flag_error(ErrUnclosed, 1'b1);
      end else begin
         emit_decoded(c, 1'b0, 1'b0);
      end
   endfunction

   function automatic void decode_char(input logic [15:0] c, input logic last);
      case (dec_mode)
         ModeEscape:  escape_char(c, last);
         ModeNumber:  number_char(c, last);
         ModeSlice:   slice_char(c, last);
         ModeSwallow: begin
            if (last) begin
               expect_result(16'd0, 1'b0, 16'd0, 16'd0, dec_saved_err, 1'b1);
               clear_string();
            end
         end
         default:     plain_char(c, last);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------

   task automatic queue_char(input logic [15:0] ch, input logic last);
      source_beat_type b;
      b.op   = OpChar;
      b.ch   = ch;
      b.last = last;
      b.cfg  = 1'b0;
      b.gap  = $urandom_range(0, gap_max);
      source_beats.push_back(b);
      chars_total++;
   endtask

   // A configuration write, or a bare pause, both wait for the decoder to go idle.
   task automatic queue_hold(input beat_op_type op, input logic value);
      source_beat_type b;
      b.op   = op;
      b.ch   = 16'd0;
      b.last = 1'b0;
      b.cfg  = value;
      b.gap  = 0;
      source_beats.push_back(b);
   endtask

   // The buffered string goes out with the last mark on its final character.
   task automatic queue_word();
      for (int i = 0; i < word_buf.size(); i++) begin
         queue_char(word_buf[i], i == word_buf.size() - 1);
      end
   endtask

   task automatic queue_text(input string s);
      word_buf.delete();
      for (int i = 0; i < s.len(); i++) begin
         word_buf.push_back(16'(s[i]));
      end
      queue_word();
   endtask

   function automatic logic [15:0] hex_digit(input int v, input logic up);
      if (v < 10) return Ch0 + 16'(v);
      return (up ? ChUpA : ChLowA) + 16'(v - 10);
   endfunction

   // Mostly printable ASCII that is not an escape or slice opener, now and then
   // any 16-bit value at all.
   function automatic logic [15:0] plain_pick();
      logic [15:0] c;
      if ($urandom_range(0, 7) == 0) return 16'($urandom());
      c = 16'($urandom_range(32, 126));
      if (c == ChBackslash || c == ChLBrace) c = ChLowA;
      return c;
   endfunction

   function automatic logic [15:0] simple_escape();
      case ($urandom_range(0, 6))
         0:       return ChLowT;
         1:       return ChLowN;
         2:       return ChLowR;
         3:       return ChQuote;
         4:       return ChApos;
         5:       return ChLBrace;
         default: return ChBackslash;
      endcase
   endfunction

   // Appends one lexical piece of a string literal to the word buffer.
   task automatic add_token();
      int   pick;
      int   n;
      logic up;
      pick = $urandom_range(0, 99);
      up   = 1'($urandom_range(0, 1));
      if (pick < 30) begin
         word_buf.push_back(plain_pick());
      end else if (pick < 45) begin
         word_buf.push_back(ChBackslash);
         word_buf.push_back(simple_escape());
      end else if (pick < 57) begin
         // Three-digit octal stays in byte range unless the lead digit is 4 or more.
         n = $urandom_range(1, 3);
         word_buf.push_back(ChBackslash);
         for (int i = 0; i < n; i++) begin
            if (i == 0 && n == 3 && $urandom_range(0, 7) != 0) begin
               word_buf.push_back(Ch0 + 16'($urandom_range(0, 3)));
            end else begin
               word_buf.push_back(Ch0 + 16'($urandom_range(0, 7)));
            end
         end
      end else if (pick < 67) begin
         n = $urandom_range(1, 2);
         word_buf.push_back(ChBackslash);
         word_buf.push_back(up ? ChUpX : ChLowX);
         for (int i = 0; i < n; i++) begin
            word_buf.push_back(hex_digit(int'($urandom_range(0, 15)),
                                         1'($urandom_range(0, 1))));
         end
      end else if (pick < 77) begin
         n = $urandom_range(1, 4);
         word_buf.push_back(ChBackslash);
         word_buf.push_back(up ? ChUpU : ChLowU);
         for (int i = 0; i < n; i++) begin
            word_buf.push_back(hex_digit(int'($urandom_range(0, 15)),
                                         1'($urandom_range(0, 1))));
         end
      end else if (pick < 92) begin
         n = $urandom_range(0, 4);
         word_buf.push_back(ChLBrace);
         for (int i = 0; i < n; i++) begin
            word_buf.push_back(plain_pick());
         end
         word_buf.push_back(ChRBrace);
      end else if (pick < 96) begin
         // Unknown or malformed escape.
         word_buf.push_back(ChBackslash);
         word_buf.push_back(16'($urandom()));
      end else begin
         word_buf.push_back(16'($urandom()));
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: feeds character beats and register writes from source_beats.
   // ------------------------------------------------------------------

   int unsigned gap_count    = 0;
   int unsigned settle_count = 0;

   always @(posedge clock) begin : drive_proc
      logic            n_valid;
      logic [15:0]     n_char;
      logic            n_last;
      logic            n_cvalid;
      logic            n_cdata;
      source_beat_type head;
      n_valid  = req_valid;
      n_char   = req_in_char;
      n_last   = req_in_last;
      n_cvalid = csr_valid;
      n_cdata  = csr_interpolation_enable;
      if (!reset) begin
         // A character beat is predicted at the edge where the decoder takes it.
         if (req_valid && !req_stall) begin
            decode_char(req_in_char, req_in_last);
            n_valid = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            interp_on = csr_interpolation_enable;
            n_cvalid  = 1'b0;
         end
         // The next beat is launched in the same step as the last acceptance
         // when no gap is due, so valid stays high across back-to-back beats.
         if (!n_valid && !n_cvalid && source_beats.size() != 0) begin
            head = source_beats[0];
            if (head.op == OpChar) begin
               if (gap_count < head.gap) begin
                  gap_count++;
               end else begin
                  n_valid   = 1'b1;
                  n_char    = head.ch;
                  n_last    = head.last;
                  gap_count = 0;
                  source_beats.delete(0);
               end
            end else begin
               // Writes and pauses wait until the decoder stays quiet, with no result pending or shown.
               if (pending_results.size() == 0 && !rsp_valid) begin
                  settle_count++;
               end else begin
                  settle_count = 0;
               end
               if (settle_count >= SettleCycles) begin
                  if (head.op == OpConfig) begin
                     n_cvalid = 1'b1;
                     n_cdata  = head.cfg;
                  end
                  settle_count = 0;
                  source_beats.delete(0);
               end
            end
         end
      end
      req_valid                <= n_valid;
      req_in_char              <= n_char;
      req_in_last              <= n_last;
      csr_valid                <= n_cvalid;
      csr_interpolation_enable <= n_cdata;
   end

   // ------------------------------------------------------------------
   // Monitor: checks every result beat against the oldest prediction and
   // applies back-pressure in random stretches.
   // ------------------------------------------------------------------

   int unsigned stall_left   = 0;
   int unsigned stall_max    = 7;
   int unsigned results_seen = 0;

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         if (fail_count < ReportLimit) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor_proc
      res_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               if (fail_count < ReportLimit) begin
                  $display("%0t: unexpected result, expected none, actual char %h closed %b",
                           $time, rsp_out_char, rsp_slice_closed);
               end
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("out_char",     want.out_char,          rsp_out_char);
               check_field("slice_closed", 16'(want.slice_closed), 16'(rsp_slice_closed));
               check_field("slice_start",  want.slice_start,       rsp_slice_start);
               check_field("slice_length", want.slice_length,      rsp_slice_length);
               check_field("error",        16'(want.error),        16'(rsp_error));
               check_field("out_last",     16'(want.out_last),     16'(rsp_out_last));
            end
            results_seen++;
            // Every 64 results the receiver picks anew, at random, between stalling
            // and taking results as fast as they come.
            if (results_seen % 64 == 0) begin
               stall_max = ($urandom_range(0, 1) != 0) ? 7 : 0;
            end
            stall_left = $urandom_range(0, stall_max);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) begin
            stall_left--;
         end
      end
   end

   // Watchdog: any channel that moves a beat keeps the run alive.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin
      int unsigned strings_done;
      int unsigned random_start;

      // Directed strings with interpolation off. A brace is then an ordinary
      // character, and it also ends the short \u escape before it.
      queue_hold(OpConfig, 1'b0);
      queue_text("{\\u41}");
      queue_text("\\x");        // ends right after the escape letter
      queue_text("\\7");        // ends with fewer octal digits than the maximum
      queue_text("\\xgz");      // empty hex number, then a swallowed character
      queue_text("\\400");      // octal value above one byte
      queue_text("\\");         // backslash as the very last character
      queue_text("\\q");        // unknown escape letter
      queue_char(16'hFFFF, 1'b0);
      queue_char(16'h0000, 1'b1);
      queue_hold(OpDrain, 1'b0);

      // With interpolation on: a plain slice, then a number result followed by
      // an opening brace on the last character, which must report the error.
      queue_hold(OpConfig, 1'b1);
      queue_text("{a}");
      queue_text("\\x4{");

      // Random strings. Most are built from well-formed pieces; some carry
      // noise, and a few end on a dangling backslash or brace.
      strings_done = 0;
      random_start = chars_total;
      while (chars_total - random_start < RandomChars) begin
         if (strings_done % 12 == 11) begin
            if ($urandom_range(0, 2) == 0) begin
               queue_hold(OpDrain, 1'b0);
            end else begin
               queue_hold(OpConfig, $urandom_range(0, 3) != 0);
            end
         end
         gap_max = ($urandom_range(0, 4) == 0) ? 0 : 7;
         word_buf.delete();
         repeat ($urandom_range(1, 6)) add_token();
         case ($urandom_range(0, 11))
            0:       word_buf.push_back(ChBackslash);
            1:       word_buf.push_back(ChLBrace);
            default: ;
         endcase
         queue_word();
         strings_done++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (source_beats.size() != 0 || req_valid || csr_valid) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/ted_pkg.sv
design/ted_decode.sv
design/ted_result_queue.sv
design/text_escape_decoder.sv
test/tb.sv
